// ----- design/four_channel_ramped_motor_drive_defines.svh -----
// Assertion macros used by the checker file.
`ifndef FOUR_CHANNEL_RAMPED_MOTOR_DRIVE_DEFINES_SVH
`define FOUR_CHANNEL_RAMPED_MOTOR_DRIVE_DEFINES_SVH

// Same-cycle implication.
`define FCRMD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcrmd: same-cycle check failed");

// Next-cycle implication.
`define FCRMD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcrmd: next-cycle check failed");

`endif

// ----- design/fcrmd_pkg.sv -----
package fcrmd_pkg;

  localparam int SPEED_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED_3 = 3'd5;

  localparam logic [7:0] ACCEL_RESET = 8'd5;
  localparam logic [7:0] MAX_MAG     = 8'd255;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         motor_index;
    logic signed [15:0] speed_request;
  } in_item_t;

  typedef struct packed {
    logic [1:0] motor_out;
    logic       reverse_pin;
    logic       forward_pin;
    logic [7:0] pwm_duty;
    logic       changed;
    logic       flush;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SET,
    S_TICK
  } state_t;

endpackage

// ----- design/four_channel_ramped_motor_drive.sv -----
// Four-channel slew-limited H-bridge drive.
// Input channel (in_valid/in_stall/in_data): set commands (motor, signed speed)
// and ramp ticks. Result channel (out_valid/out_stall/out_data): per-motor
// direction pins, PWM duty, changed, flush and last flags.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while idle. Index 0 accel step, 1 ramp enable, 2..5 minimum speeds.
// Sequencing: an item is accepted in idle; a set, or a tick with ramp on,
// then stalls the input until back in idle. A set with ramp on stores the
// target in S_SET, no result. A set with ramp off gives one result, loaded
// into the output register from S_SET. A tick gives MOTOR_COUNT results,
// one per cycle while the receiver does not stall; the single shared step
// unit visits one motor a cycle. A tick with ramp off is dropped.
// Receiver stall: the output register holds its item; the sequencer waits
// and the input stays stalled until the slot frees.
// Reset: speeds and targets zero, accel step 5, ramp on, minimums zero.
module four_channel_ramped_motor_drive #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fcrmd_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fcrmd_pkg::out_item_t              out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcrmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcrmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fcrmd_pkg::*;

  localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic [MIDX_W-1:0] LAST_MOTOR = MIDX_W'(MOTOR_COUNT - 1);

  // Sequencer state
  state_t              state_r, state_nxt;
  logic [MIDX_W-1:0]   cnt_r, cnt_nxt;      // motor visited by the tick
  logic                any_r, any_nxt;      // some motor changed this tick
  in_item_t            req_r;               // latched item

  // Motor state
  logic signed [SPEED_W-1:0] cur_r [MOTOR_COUNT];
  logic signed [SPEED_W-1:0] tgt_r [MOTOR_COUNT];

  // Config
  logic [7:0] accel_r;
  logic       ramp_r;
  logic [7:0] min_r [4];

  // Output register
  logic       out_valid_r;
  out_item_t  out_data_r;
  out_item_t  out_nxt;

  // Datapath
  logic                      idx_ok;
  logic [MIDX_W-1:0]         set_idx, sel_idx;
  logic signed [SPEED_W-1:0] cur_sel, tgt_sel;
  logic signed [16:0]        sp_ext;
  logic [16:0]               sp_abs;
  logic [7:0]                min_sel, mag8;
  logic signed [SPEED_W-1:0] clamp_speed, step_speed, new_speed;
  logic signed [9:0]         diff, a10, cur10;
  logic                      chg, is_last, out_free;
  logic                      out_load, tgt_we;

  assign idx_ok  = int'(req_r.motor_index) < MOTOR_COUNT;
  assign set_idx = MIDX_W'(req_r.motor_index);
  // one read port on the speed arrays: tick counter or set index
  assign sel_idx = (state_r == S_TICK) ? cnt_r : set_idx;
  assign cur_sel = cur_r[sel_idx];
  assign tgt_sel = tgt_r[sel_idx];

  // Clamp of a set request: magnitude into [min, 255], zero stays zero
  assign sp_ext  = 17'(req_r.speed_request);
  assign sp_abs  = sp_ext[16] ? 17'(-sp_ext) : 17'(sp_ext);
  assign min_sel = min_r[req_r.motor_index];

  always_comb begin
    if (sp_abs > 17'(MAX_MAG)) begin
      mag8 = MAX_MAG;
    end else if (sp_abs[7:0] < min_sel) begin
      mag8 = min_sel;
    end else begin
      mag8 = sp_abs[7:0];
    end
    if (sp_abs == 17'd0) begin
      clamp_speed = '0;
    end else if (sp_ext[16]) begin
      clamp_speed = -$signed({1'b0, mag8});
    end else begin
      clamp_speed = $signed({1'b0, mag8});
    end
  end

  // Shared step unit: move current toward target by at most accel step
  assign cur10 = 10'(cur_sel);
  assign diff  = 10'(tgt_sel) - cur10;
  assign a10   = $signed({2'b00, accel_r});

  always_comb begin
    if (diff > a10) begin
      step_speed = SPEED_W'(cur10 + a10);
    end else if (diff < -a10) begin
      step_speed = SPEED_W'(cur10 - a10);
    end else begin
      step_speed = tgt_sel;
    end
  end

  assign new_speed = (state_r == S_TICK) ? step_speed : clamp_speed;
  assign chg       = new_speed != cur_sel;
  assign is_last   = (state_r == S_TICK) ? (cnt_r == LAST_MOTOR) : 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    out_nxt.motor_out   = (state_r == S_TICK) ? 2'(cnt_r) : req_r.motor_index;
    out_nxt.reverse_pin = new_speed < 0;
    out_nxt.forward_pin = new_speed > 0;
    out_nxt.pwm_duty    = new_speed[SPEED_W-1] ? 8'(-new_speed) : new_speed[7:0];
    out_nxt.changed     = chg;
    out_nxt.last        = is_last;
    // set with ramp off always writes the peripherals
    out_nxt.flush       = (state_r == S_TICK) ? (is_last && (any_r || chg)) : 1'b1;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == OP_SET) begin
            state_nxt = S_SET;
          end else if (ramp_r) begin
            state_nxt = S_TICK;
          end
        end
      end
      S_SET: begin
        if (!idx_ok || ramp_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (out_free && cnt_r == LAST_MOTOR) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall = 1'b1;
    tgt_we   = 1'b0;
    out_load = 1'b0;
    cnt_nxt  = cnt_r;
    any_nxt  = any_r;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cnt_nxt  = '0;
        any_nxt  = 1'b0;
      end
      S_SET: begin
        tgt_we   = idx_ok;
        out_load = idx_ok && !ramp_r && out_free;
      end
      S_TICK: begin
        out_load = out_free;
        if (out_free) begin
          cnt_nxt = cnt_r + 1'b1;
          any_nxt = any_r || chg;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
      accel_r     <= ACCEL_RESET;
      ramp_r      <= 1'b1;
      for (int i = 0; i < 4; i++) begin
        min_r[i] <= '0;
      end
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        cur_r[m] <= '0;
        tgt_r[m] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      any_r   <= any_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (tgt_we) begin
        tgt_r[sel_idx] <= clamp_speed;
      end
      if (out_load) begin
        cur_r[sel_idx] <= new_speed;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ACCEL_STEP:  accel_r  <= cfg_data;
          REG_RAMP_ENABLE: ramp_r   <= cfg_data[0];
          REG_MIN_SPEED_0: min_r[0] <= cfg_data;
          REG_MIN_SPEED_1: min_r[1] <= cfg_data;
          REG_MIN_SPEED_2: min_r[2] <= cfg_data;
          REG_MIN_SPEED_3: min_r[3] <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/fcrmd_checker.sv -----
`include "four_channel_ramped_motor_drive_defines.svh"

module fcrmd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input fcrmd_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input fcrmd_pkg::out_item_t out_data
);
  import fcrmd_pkg::*;

  logic pins_ok;
  logic set_acc;

  // pins low exactly at zero duty, never both high
  assign pins_ok = ((out_data.pwm_duty == 8'd0) ==
                    (!out_data.reverse_pin && !out_data.forward_pin)) &&
                   !(out_data.reverse_pin && out_data.forward_pin);
  assign set_acc = in_valid && !in_stall && (in_data.opcode == OP_SET);

  // flush only ever rides on the final result of an item
  `FCRMD_ASSERT_IMP(a_flush_last, clk, rst_n, out_valid && out_data.flush, out_data.last)

  `FCRMD_ASSERT_IMP(a_pins_duty, clk, rst_n, out_valid, pins_ok)

  // a set command always occupies the sequencer in the cycle after its accept
  `FCRMD_ASSERT_NXT(a_set_busy, clk, rst_n, set_acc, in_stall)

  `FCRMD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                    out_valid && $stable(out_data))

endmodule

bind four_channel_ramped_motor_drive fcrmd_checker u_fcrmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
